>>> sv/cglb_pkg.sv
// ----------------------------------------------------------------------------
// cglb_pkg: shared types and constants
// Types and constants for the color gradient table builder.
// ----------------------------------------------------------------------------
package cglb_pkg;

    localparam int MAX_STOPS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = IDX_W + 1;

    localparam logic [6:0] FULL_PCT = 7'd100;
    localparam logic [6:0] STEP_MIN = 7'd2;
    localparam logic [6:0] STEP_MAX = 7'd64;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_GEN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] stop_percent;
        logic [7:0] stop_red;
        logic [7:0] stop_green;
        logic [7:0] stop_blue;
    } cglb_in_t;

    typedef struct packed {
        logic [14:0] position;
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic        empty_error;
        logic        overflow;
        logic        last;
    } cglb_out_t;

    typedef struct packed {
        logic [6:0] pct;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cglb_stop_t;

    // Shared control broadcast to every cell
    typedef struct packed {
        logic             load;
        logic             rotate;
        logic             match;
        logic             full;
        logic [CNT_W-1:0] count;
        cglb_stop_t       stop;
    } cglb_ctrl_t;

endpackage

>>> sv/cglb_cell.sv
// ----------------------------------------------------------------------------
// cglb_cell: one slot of the stop chain
// Holds one stop; sorted insert shifts from the left, rotate pulls from right.
// ----------------------------------------------------------------------------
module cglb_cell
    import cglb_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  cglb_ctrl_t       ctrl,
    input  cglb_stop_t       prev_stop,
    input  logic             prev_lt,
    input  cglb_stop_t       next_stop,
    output cglb_stop_t       stop,
    output logic             lt,
    output logic             eq
);

    cglb_stop_t stop_reg;
    cglb_stop_t stop_next;
    logic       used;
    logic       in_range;

    assign used     = {1'b0, idx} < ctrl.count;
    assign in_range = {1'b0, idx} <= ctrl.count;
    assign lt       = used && (stop_reg.pct < ctrl.stop.pct);
    assign eq       = used && (stop_reg.pct == ctrl.stop.pct);
    assign stop     = stop_reg;

    always_comb
    begin
        stop_next = stop_reg;
        if (ctrl.rotate)
        begin
            stop_next = next_stop;
        end
        else if (ctrl.load)
        begin
            if (ctrl.match)
            begin
                if (eq)
                    stop_next = ctrl.stop;
            end
            else if (!ctrl.full && in_range)
            begin
                if (prev_lt && !lt)
                    stop_next = ctrl.stop;
                else if (!prev_lt)
                    stop_next = prev_stop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg <= stop_next;
    end

endmodule

>>> sv/cglb_div.sv
// ----------------------------------------------------------------------------
// cglb_div: restoring divider, one quotient bit per cycle
// 29-bit dividend, 13-bit divisor, 16-bit quotient known to fit.
// ----------------------------------------------------------------------------
module cglb_div
    import cglb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [28:0] num,
    input  logic [12:0] den,
    output logic        done,
    output logic [15:0] quo
);

    logic [12:0] rem_reg, rem_next;
    logic [15:0] sh_reg, sh_next;
    logic [12:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [13:0] trial;
    logic        ge;

    assign trial = {rem_reg, sh_reg[15]};
    assign ge    = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = sh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num[28:16];
            sh_next  = num[15:0];
            den_next = den;
            cnt_next = 5'd16;
        end
        else if (cnt_reg != 5'd0)
        begin
            rem_next  = ge ? 13'(trial - {1'b0, den_reg}) : trial[12:0];
            sh_next   = {sh_reg[14:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

endmodule

>>> sv/color_gradient_lut_builder_top.sv
// Sequence: load and clear are handled in the idle state. Generate turns the ring once
//   to find the first and last stops, fetches the first pair, then per entry advances
//   past stops, computes, divides and emits, then turns the ring back into order.
// Throughput: one request at a time; a new request is taken once the ring is back in
//   order after the last entry.
// Reset: stop count, overflow flag and control clear at once; step_count goes to 64.
// ----------------------------------------------------------------------------
// color_gradient_lut_builder_top: gradient stop table and LUT generator
// Stops live in a chain of cells kept sorted by percent. Generate walks the
// chain as a ring, interpolating between adjacent stops with four dividers.
// ----------------------------------------------------------------------------
module color_gradient_lut_builder_top
    import cglb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  cglb_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output cglb_out_t out_data,
    input  logic      cfg_we,
    input  logic [6:0] cfg_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PRE     = 4'd1;
    localparam logic [3:0] ST_INIT_LO = 4'd2;
    localparam logic [3:0] ST_INIT_HI = 4'd3;
    localparam logic [3:0] ST_ADV     = 4'd4;
    localparam logic [3:0] ST_CALC    = 4'd5;
    localparam logic [3:0] ST_MUL     = 4'd6;
    localparam logic [3:0] ST_DIV     = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;
    localparam logic [3:0] ST_RESTORE = 4'd9;
    localparam logic [3:0] ST_EMPTY   = 4'd10;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_STOPS);

    logic [3:0]       state_reg, state_next;
    logic [6:0]       step_count_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] rot_reg, rot_next;
    logic [5:0]       i_reg, i_next;
    logic             v0_reg, v0_next;
    cglb_stop_t       first_reg, first_next;
    cglb_stop_t       last_reg, last_next;
    cglb_stop_t       lo_reg, lo_next;
    cglb_stop_t       hi_reg, hi_next;
    logic [12:0]      a_reg, a_next;
    logic [12:0]      b_reg, b_next;
    logic [12:0]      d_reg, d_next;
    logic             out_valid_reg, out_valid_next;
    cglb_out_t        out_reg, out_next;

    // cell chain
    cglb_ctrl_t       ctrl;
    cglb_stop_t       cell_q  [MAX_STOPS];
    logic             cell_lt [MAX_STOPS];
    logic [MAX_STOPS-1:0] cell_eq;
    cglb_stop_t       head;

    // datapath
    logic             accept;
    logic             out_free;
    logic [6:0]       steps;
    logic [5:0]       s;
    logic [12:0]      t;
    logic [12:0]      hi_s;
    logic [12:0]      lo_s;
    cglb_stop_t       fetch;
    logic             fetch_rot;
    logic             use_fetch;
    logic             ring_rot;
    logic             div_start;
    logic [20:0]      num_r, num_g, num_b;
    logic [3:0]       div_done;
    logic [15:0]      q_pos, q_r, q_g, q_b;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign head     = cell_q[0];

    assign steps = (step_count_reg < STEP_MIN) ? STEP_MIN :
                   (step_count_reg > STEP_MAX) ? STEP_MAX : step_count_reg;
    assign s     = 6'(steps - 7'd1);
    assign t     = 13'(7'd100 * i_reg);
    assign hi_s  = 13'(hi_reg.pct * s);
    assign lo_s  = 13'(lo_reg.pct * s);

    // next stop of the virtual work list: implied 0 stop, stored stops up to 100,
    // then an implied 100 stop carrying the last stored color
    always_comb
    begin
        fetch     = last_reg;
        fetch.pct = FULL_PCT;
        fetch_rot = 1'b0;
        if (v0_reg)
        begin
            fetch     = first_reg;
            fetch.pct = 7'd0;
        end
        else if ((rot_reg < count_reg) && (head.pct <= FULL_PCT))
        begin
            fetch     = head;
            fetch_rot = 1'b1;
        end
    end

    assign ctrl.load   = accept && (in_data.kind == KIND_LOAD);
    assign ctrl.rotate = ring_rot;
    assign ctrl.match  = |cell_eq;
    assign ctrl.full   = (count_reg == FULL_CNT);
    assign ctrl.count  = count_reg;
    assign ctrl.stop   = '{pct: in_data.stop_percent, red: in_data.stop_red,
                           green: in_data.stop_green, blue: in_data.stop_blue};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_STOPS; gi++)
        begin : g_cell
            cglb_cell u_cell (
                .clk       (clk),
                .idx       (IDX_W'(gi)),
                .ctrl      (ctrl),
                .prev_stop ((gi == 0) ? cell_q[0] : cell_q[(gi + MAX_STOPS - 1) % MAX_STOPS]),
                .prev_lt   ((gi == 0) ? 1'b1 : cell_lt[(gi + MAX_STOPS - 1) % MAX_STOPS]),
                .next_stop (cell_q[(gi + 1) % MAX_STOPS]),
                .stop      (cell_q[gi]),
                .lt        (cell_lt[gi]),
                .eq        (cell_eq[gi])
            );
        end
    endgenerate

    // products feed the dividers directly; the dividers register them
    assign num_r = 21'(lo_reg.red   * a_reg) + 21'(hi_reg.red   * b_reg);
    assign num_g = 21'(lo_reg.green * a_reg) + 21'(hi_reg.green * b_reg);
    assign num_b = 21'(lo_reg.blue  * a_reg) + 21'(hi_reg.blue  * b_reg);
    assign div_start = (state_reg == ST_MUL);

    cglb_div u_div_pos (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num({8'd0, t, 8'd0}), .den({7'd0, s}), .done(div_done[0]), .quo(q_pos));
    cglb_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num({num_r, 8'd0}), .den(d_reg), .done(div_done[1]), .quo(q_r));
    cglb_div u_div_g (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num({num_g, 8'd0}), .den(d_reg), .done(div_done[2]), .quo(q_g));
    cglb_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num({num_b, 8'd0}), .den(d_reg), .done(div_done[3]), .quo(q_b));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rot_next       = rot_reg;
        i_next         = i_reg;
        v0_next        = v0_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        use_fetch      = 1'b0;
        ring_rot       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.kind)
                        KIND_LOAD:
                        begin
                            if (!ctrl.match)
                            begin
                                if (ctrl.full)
                                    ovf_next = 1'b1;
                                else
                                    count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_GEN:
                        begin
                            rot_next   = '0;
                            state_next = (count_reg == '0) ? ST_EMPTY : ST_PRE;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PRE:
            begin
                // one full turn of the ring to pick up first and last stops
                ring_rot = 1'b1;
                if (rot_reg == '0)
                    first_next = head;
                if (rot_reg == count_reg - CNT_W'(1))
                    last_next = head;
                rot_next = rot_reg + CNT_W'(1);
                if (rot_reg == CNT_W'(MAX_STOPS - 1))
                begin
                    rot_next   = '0;
                    v0_next    = (first_reg.pct != 7'd0);
                    i_next     = '0;
                    state_next = ST_INIT_LO;
                end
            end
            ST_INIT_LO, ST_INIT_HI:
            begin
                use_fetch = 1'b1;
                if (state_reg == ST_INIT_LO)
                begin
                    lo_next    = fetch;
                    state_next = ST_INIT_HI;
                end
                else
                begin
                    hi_next    = fetch;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (hi_s < t)
                begin
                    use_fetch = 1'b1;
                    lo_next   = hi_reg;
                    hi_next   = fetch;
                end
                else
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                a_next     = hi_s - t;
                b_next     = t - lo_s;
                d_next     = 13'((hi_reg.pct - lo_reg.pct) * s);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done[0])
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.position    = q_pos[14:0];
                    out_next.out_red     = q_r;
                    out_next.out_green   = q_g;
                    out_next.out_blue    = q_b;
                    out_next.empty_error = 1'b0;
                    out_next.overflow    = ovf_reg;
                    out_next.last        = (i_reg == s);
                    if (i_reg == s)
                    begin
                        state_next = ST_RESTORE;
                    end
                    else
                    begin
                        i_next     = i_reg + 6'd1;
                        state_next = ST_ADV;
                    end
                end
            end
            ST_RESTORE:
            begin
                // finish the turn so the ring is back in sorted order
                if (rot_reg == CNT_W'(MAX_STOPS))
                begin
                    rot_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ring_rot = 1'b1;
                    rot_next = rot_reg + CNT_W'(1);
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.empty_error = 1'b1;
                    out_next.overflow    = ovf_reg;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (use_fetch)
        begin
            v0_next = 1'b0;
            if (fetch_rot)
            begin
                ring_rot = 1'b1;
                rot_next = rot_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_count_reg <= STEP_MAX;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            rot_reg        <= '0;
            i_reg          <= '0;
            v0_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            rot_reg        <= rot_next;
            i_reg          <= i_next;
            v0_reg         <= v0_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                step_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        d_reg     <= d_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stop count above table size");

    a_rot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ring_rot |-> (state_reg != ST_IDLE))
        else $error("ring rotated while idle");

    a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load && ctrl.full && !ctrl.match) |=> ovf_reg)
        else $error("dropped stop did not set overflow");

    a_restore_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESTORE && rot_reg == CNT_W'(MAX_STOPS)) |=> (state_reg == ST_IDLE))
        else $error("ring restore did not finish");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: color gradient table builder check
// Drives stop loads, clears and generate requests with random idling and
// stalls, predicts every table entry and compares each one field by field.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted table entries and checks them in order
class lut_scoreboard;
    cglb_pkg::cglb_out_t entry_q[$];
    logic [6:0] stop_pct[16];
    logic [7:0] stop_rgb[16][3];
    int unsigned n_stops;
    bit          ovf;
    int unsigned steps_reg;
    int unsigned errors;

    function new();
        n_stops   = 0;
        ovf       = 0;
        steps_reg = 64;
        errors    = 0;
    endfunction

    function void note_request(cglb_pkg::cglb_in_t req);
        int unsigned pos;
        int unsigned k;
        int unsigned n;
        int unsigned steps;
        int unsigned s;
        int unsigned lo;
        int unsigned hi;
        longint unsigned t;
        longint unsigned a;
        longint unsigned b;
        longint unsigned d;
        longint unsigned num;
        logic [6:0] wp[18];
        logic [7:0] wc[18][3];
        bit has_full;
        cglb_pkg::cglb_out_t e;
        if (req.kind == cglb_pkg::KIND_LOAD)
        begin
            pos = 0;
            while (pos < n_stops && stop_pct[pos] < req.stop_percent)
                pos++;
            if (!(pos < n_stops && stop_pct[pos] == req.stop_percent))
            begin
                if (n_stops >= cglb_pkg::MAX_STOPS)
                begin
                    ovf = 1;
                    return;
                end
                for (k = n_stops; k > pos; k--)
                begin
                    stop_pct[k] = stop_pct[k-1];
                    stop_rgb[k] = stop_rgb[k-1];
                end
                n_stops++;
            end
            stop_pct[pos]    = req.stop_percent;
            stop_rgb[pos][0] = req.stop_red;
            stop_rgb[pos][1] = req.stop_green;
            stop_rgb[pos][2] = req.stop_blue;
        end
        else if (req.kind == cglb_pkg::KIND_CLEAR)
        begin
            n_stops = 0;
            ovf     = 0;
        end
        else if (req.kind == cglb_pkg::KIND_GEN)
        begin
            if (n_stops == 0)
            begin
                e = '0;
                e.empty_error = 1;
                e.overflow    = ovf;
                e.last        = 1;
                entry_q.push_back(e);
                return;
            end
            n = 0;
            if (stop_pct[0] != 0)
            begin
                wp[0] = 0;
                wc[0] = stop_rgb[0];
                n = 1;
            end
            for (k = 0; k < n_stops; k++)
            begin
                wp[n] = stop_pct[k];
                wc[n] = stop_rgb[k];
                n++;
            end
            has_full = 0;
            for (k = 0; k < n; k++)
                if (wp[k] == cglb_pkg::FULL_PCT)
                    has_full = 1;
            if (!has_full)
            begin
                pos = 0;
                while (pos < n && wp[pos] < cglb_pkg::FULL_PCT)
                    pos++;
                for (k = n; k > pos; k--)
                begin
                    wp[k] = wp[k-1];
                    wc[k] = wc[k-1];
                end
                wp[pos] = cglb_pkg::FULL_PCT;
                wc[pos] = stop_rgb[n_stops-1];
                n++;
            end
            steps = steps_reg;
            if (steps < cglb_pkg::STEP_MIN) steps = cglb_pkg::STEP_MIN;
            if (steps > cglb_pkg::STEP_MAX) steps = cglb_pkg::STEP_MAX;
            s  = steps - 1;
            lo = 0;
            hi = 1;
            for (int unsigned i = 0; i < steps; i++)
            begin
                t = 100 * i;
                while (hi + 1 < n && longint'(wp[hi]) * s < t)
                begin
                    lo++;
                    hi++;
                end
                a = longint'(wp[hi]) * s - t;
                b = t - longint'(wp[lo]) * s;
                d = longint'(wp[hi] - wp[lo]) * s;
                e = '0;
                e.position = 15'((t * 256) / s);
                num = wc[lo][0] * a + wc[hi][0] * b;
                e.out_red = (d != 0) ? 16'((num * 256) / d) : 16'd0;
                num = wc[lo][1] * a + wc[hi][1] * b;
                e.out_green = (d != 0) ? 16'((num * 256) / d) : 16'd0;
                num = wc[lo][2] * a + wc[hi][2] * b;
                e.out_blue = (d != 0) ? 16'((num * 256) / d) : 16'd0;
                e.overflow = ovf;
                e.last     = (i + 1 == steps);
                entry_q.push_back(e);
            end
        end
    endfunction

    function void check_entry(cglb_pkg::cglb_out_t got);
        cglb_pkg::cglb_out_t exp_e;
        if (entry_q.size() == 0)
        begin
            $display("%0t: unexpected entry %h", $realtime, got);
            errors++;
            return;
        end
        exp_e = entry_q.pop_front();
        if (got.position !== exp_e.position)
            $display("%0t: position exp %0d got %0d", $realtime, exp_e.position, got.position);
        if (got.out_red !== exp_e.out_red)
            $display("%0t: red exp %0d got %0d", $realtime, exp_e.out_red, got.out_red);
        if (got.out_green !== exp_e.out_green)
            $display("%0t: green exp %0d got %0d", $realtime, exp_e.out_green, got.out_green);
        if (got.out_blue !== exp_e.out_blue)
            $display("%0t: blue exp %0d got %0d", $realtime, exp_e.out_blue, got.out_blue);
        if (got.empty_error !== exp_e.empty_error)
            $display("%0t: empty_error exp %0b got %0b", $realtime,
                     exp_e.empty_error, got.empty_error);
        if (got.overflow !== exp_e.overflow)
            $display("%0t: overflow exp %0b got %0b", $realtime, exp_e.overflow, got.overflow);
        if (got.last !== exp_e.last)
            $display("%0t: last exp %0b got %0b", $realtime, exp_e.last, got.last);
        if (got !== exp_e)
            errors++;
    endfunction
endclass

module testbench;
    import cglb_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    cglb_in_t   in_data;
    logic       out_valid;
    logic       out_stall;
    cglb_out_t  out_data;
    logic       cfg_we;
    logic [6:0] cfg_data;

    lut_scoreboard sb;

    // Idle percentages per phase, in percent
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // Long receiver hold-off, in cycles, served by the receiver process
    int unsigned hold_cycles;

    color_gradient_lut_builder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Send one request: random idle first, then hold valid until accepted.
    // Valid stays up after acceptance; idling or drain drops it.
    task automatic send_request(input cglb_in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_data  <= req;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(req);
        @(negedge clk);
    endtask

    // Wait for all expected entries, then let trailing work drain.
    task automatic drain;
        in_valid <= 0;
        while (sb.entry_q.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_steps(input logic [6:0] value);
        drain();
        cfg_data <= value;
        cfg_we   <= 1;
        @(negedge clk);
        cfg_we   <= 0;
        sb.steps_reg = value;
    endtask

    function automatic cglb_in_t make_req(logic [1:0] k, logic [6:0] p,
                                          logic [7:0] r, logic [7:0] g, logic [7:0] b);
        cglb_in_t q;
        q.kind         = k;
        q.stop_percent = p;
        q.stop_red     = r;
        q.stop_green   = g;
        q.stop_blue    = b;
        return q;
    endfunction

    function automatic cglb_in_t rand_load();
        logic [6:0] p;
        // mostly in range, sometimes above 100 up to full field width
        p = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
        if ($urandom_range(5) == 0)
            p = ($urandom_range(1) != 0) ? 7'd0 : FULL_PCT;
        return make_req(KIND_LOAD, p, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                out_stall <= 1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: sample results at the rising edge.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_entry(out_data);

    initial
    begin
        int unsigned phase;
        int unsigned loads;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: empty generate, corners, replacement, overflow, odd kind
        send_request(make_req(KIND_GEN, 7'd0, 8'd0, 8'd0, 8'd0));
        write_steps(7'd2);
        send_request(make_req(KIND_LOAD, 7'd50, 8'd255, 8'd0, 8'd128));
        send_request(make_req(KIND_GEN, 7'd0, 8'd0, 8'd0, 8'd0));
        send_request(make_req(KIND_LOAD, 7'd0, 8'd0, 8'd255, 8'd255));
        send_request(make_req(KIND_LOAD, FULL_PCT, 8'd255, 8'd255, 8'd0));
        send_request(make_req(KIND_LOAD, 7'd50, 8'd1, 8'd2, 8'd3));
        write_steps(7'd5);
        send_request(make_req(KIND_GEN, 7'd0, 8'd0, 8'd0, 8'd0));
        send_request(make_req(KIND_LOAD, 7'd127, 8'd255, 8'd255, 8'd255));
        send_request(make_req(2'd3, 7'd127, 8'd255, 8'd255, 8'd255));
        send_request(make_req(KIND_CLEAR, 7'd0, 8'd0, 8'd0, 8'd0));
        send_request(make_req(KIND_LOAD, 7'd127, 8'd9, 8'd8, 8'd7));
        send_request(make_req(KIND_GEN, 7'd0, 8'd0, 8'd0, 8'd0));
        for (int i = 0; i < 18; i++)
            send_request(make_req(KIND_LOAD, 7'(i * 6), 8'(i * 15), 8'(255 - i), 8'(i)));
        write_steps(7'd0);
        send_request(make_req(KIND_GEN, 7'd0, 8'd0, 8'd0, 8'd0));
        write_steps(7'd127);
        send_request(make_req(KIND_GEN, 7'd0, 8'd0, 8'd0, 8'd0));
        send_request(make_req(KIND_CLEAR, 7'd0, 8'd0, 8'd0, 8'd0));

        // Random phases: well-formed runs of loads then a generate, with noise
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            case (phase)
                0: write_steps(7'd64);
                3: write_steps(7'd1);
                5: write_steps(7'd65);
                default: write_steps(7'($urandom_range(2, 12)));
            endcase
            if (phase == 0)
                hold_cycles = 3000;
            for (int r = 0; r < 8; r++)
            begin
                if ($urandom_range(3) == 0)
                    send_request(make_req(KIND_CLEAR, 7'd0, 8'd0, 8'd0, 8'd0));
                loads = $urandom_range(0, 5) == 0 ? $urandom_range(14, 20)
                                                  : $urandom_range(1, 5);
                for (int j = 0; j < loads; j++)
                    send_request(rand_load());
                if ($urandom_range(7) == 0)
                    send_request(make_req(2'd3, 7'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom)));
                send_request(make_req(KIND_GEN, 7'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom)));
            end
        end

        drain();
        if (sb.errors == 0 && sb.entry_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #300ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> color_gradient_lut_builder_top.f
sv/cglb_pkg.sv
sv/cglb_cell.sv
sv/cglb_div.sv
sv/color_gradient_lut_builder_top.sv
bench/testbench.sv
